>>> sv/c2d_pkg.sv
// Package: constants, types and address helpers for the conv2d block.
package c2d_pkg;
    localparam int MaxHeight      = 32;
    localparam int MaxWidth       = 32;
    localparam int MaxInChannels  = 16;
    localparam int MaxOutChannels = 16;
    localparam int MaxKernel      = 5;

    localparam int ActDepth = MaxHeight * MaxWidth * MaxInChannels;
    localparam int WgtDepth = MaxOutChannels * MaxInChannels * MaxKernel * MaxKernel;
    localparam int BiasDepth = MaxOutChannels;
    localparam int ActAw  = $clog2(ActDepth);
    localparam int WgtAw  = $clog2(WgtDepth);
    localparam int BiasAw = (BiasDepth > 1) ? $clog2(BiasDepth) : 1;
    localparam int AccW   = 48;

    typedef enum logic [1:0] {
        OP_LOAD_ACT  = 2'd0,
        OP_LOAD_WGT  = 2'd1,
        OP_LOAD_BIAS = 2'd2,
        OP_COMPUTE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        REG_MAP_H  = 3'd0,
        REG_MAP_W  = 3'd1,
        REG_KER_H  = 3'd2,
        REG_KER_W  = 3'd3,
        REG_IN_CH  = 3'd4,
        REG_OUT_CH = 3'd5
    } reg_idx_t;

    // clamped configuration seen by the datapath
    typedef struct packed {
        logic [5:0] h;
        logic [5:0] w;
        logic [2:0] kh;
        logic [2:0] kw;
        logic [4:0] nin;
        logic [4:0] nout;
    } cfg_t;

    // compute job handed from front to back
    typedef struct packed {
        logic [4:0] row;
        logic [4:0] col;
        logic [3:0] oc;
    } job_t;

    function automatic logic [ActAw-1:0] act_addr(input logic [4:0] r, input logic [4:0] c,
                                                  input logic [3:0] ic);
        logic [31:0] a;
        a = (32'(r) * MaxWidth + 32'(c)) * MaxInChannels + 32'(ic);
        return a[ActAw-1:0];
    endfunction

    function automatic logic [WgtAw-1:0] wgt_addr(input logic [3:0] oc, input logic [3:0] ic,
                                                  input logic [2:0] tr, input logic [2:0] tc);
        logic [31:0] a;
        a = ((32'(oc) * MaxInChannels + 32'(ic)) * MaxKernel + 32'(tr)) * MaxKernel + 32'(tc);
        return a[WgtAw-1:0];
    endfunction

    function automatic logic [5:0] clamp6(input logic [5:0] v, input int hi);
        if (v == 6'd0) return 6'd1;
        if (32'(v) > hi) return 6'(hi);
        return v;
    endfunction
endpackage

>>> sv/c2d_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module c2d_ram #(
    parameter int Width = 16,
    parameter int Depth = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

>>> sv/c2d_front.sv
// Front end: config registers, item decode, store writes, compute job queue.
module c2d_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [5:0]            cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [47:0]           s_tdata,
    output c2d_pkg::cfg_t         cfg,
    output logic                  act_we,
    output logic [c2d_pkg::ActAw-1:0] act_waddr,
    output logic                  wgt_we,
    output logic [c2d_pkg::WgtAw-1:0] wgt_waddr,
    output logic                  bias_we,
    output logic [c2d_pkg::BiasAw-1:0] bias_waddr,
    output logic [15:0]           wdata,
    output logic                  job_valid,
    input  logic                  job_ready,
    output c2d_pkg::job_t         job
);
    import c2d_pkg::*;

    logic [5:0] mh_reg, mw_reg;
    logic [2:0] kh_reg, kw_reg;
    logic [4:0] nin_reg, nout_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mh_reg <= 6'd32; mw_reg <= 6'd32; kh_reg <= 3'd3; kw_reg <= 3'd3;
            nin_reg <= 5'd16; nout_reg <= 5'd16;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MAP_H:  mh_reg <= cfg_data;
                REG_MAP_W:  mw_reg <= cfg_data;
                REG_KER_H:  kh_reg <= cfg_data[2:0];
                REG_KER_W:  kw_reg <= cfg_data[2:0];
                REG_IN_CH:  nin_reg <= cfg_data[4:0];
                REG_OUT_CH: nout_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.h    = clamp6(mh_reg, MaxHeight);
        cfg.w    = clamp6(mw_reg, MaxWidth);
        cfg.kh   = 3'(clamp6({3'd0, kh_reg}, MaxKernel));
        cfg.kw   = 3'(clamp6({3'd0, kw_reg}, MaxKernel));
        cfg.nin  = 5'(clamp6({1'b0, nin_reg}, MaxInChannels));
        cfg.nout = 5'(clamp6({1'b0, nout_reg}, MaxOutChannels));
    end

    op_t        op;
    logic [4:0] row, col;
    logic [3:0] ic, oc;
    logic [2:0] tr, tc;
    assign op   = op_t'(s_tdata[1:0]);
    assign row  = s_tdata[6:2];
    assign col  = s_tdata[11:7];
    assign ic   = s_tdata[15:12];
    assign oc   = s_tdata[19:16];
    assign tr   = s_tdata[22:20];
    assign tc   = s_tdata[25:23];
    assign wdata = s_tdata[41:26];

    // two-entry job queue
    job_t       q_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       acc_in, push, pop, in_range;

    // loads hold off until no compute is queued or running, so none overtakes one
    assign s_tready = (cnt_reg != 2'd2)
                      && ((op == OP_COMPUTE) || ((cnt_reg == 2'd0) && job_ready));
    assign acc_in   = s_tvalid && s_tready;
    assign in_range = ({1'b0, row} < cfg.h) && ({1'b0, col} < cfg.w) && ({1'b0, oc} < cfg.nout);
    assign push     = acc_in && (op == OP_COMPUTE) && in_range;
    assign job_valid = (cnt_reg != 2'd0);
    assign pop      = job_valid && job_ready;
    assign job      = q_reg[rp_reg];

    assign act_we    = acc_in && (op == OP_LOAD_ACT);
    assign act_waddr = act_addr(row, col, ic);
    assign wgt_we    = acc_in && (op == OP_LOAD_WGT) && (32'(tr) < MaxKernel)
                       && (32'(tc) < MaxKernel);
    assign wgt_waddr = wgt_addr(oc, ic, tr, tc);
    assign bias_we   = acc_in && (op == OP_LOAD_BIAS);
    assign bias_waddr = BiasAw'(oc);

    always_ff @(posedge aclk) begin
        if (push) q_reg[wp_reg] <= '{row: row, col: col, oc: oc};
        if (!aresetn) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

>>> sv/c2d_back.sv
// Back end: walks channels and taps on one MAC, rounds, saturates, applies ReLU.
module c2d_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  c2d_pkg::cfg_t         cfg,
    input  logic                  job_valid,
    output logic                  job_ready,
    input  c2d_pkg::job_t         job,
    output logic [c2d_pkg::ActAw-1:0] act_raddr,
    input  logic [15:0]           act_rdata,
    output logic [c2d_pkg::WgtAw-1:0] wgt_raddr,
    input  logic [15:0]           wgt_rdata,
    output logic [c2d_pkg::BiasAw-1:0] bias_raddr,
    input  logic [15:0]           bias_rdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,
    output logic                  m_tuser
);
    import c2d_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_BIAS = 5'b00010,
        ST_RUN  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_OUT  = 5'b10000
    } st_t;

    st_t        st_reg, st_next;
    job_t       job_reg;
    logic [3:0] ic_reg;
    logic [2:0] fh_reg, fw_reg;
    logic       rd_v_reg, mul_v_reg;
    logic signed [31:0] prod_reg;
    logic signed [AccW-1:0] acc_reg;
    logic [31:0] out_reg;
    logic        sat_reg;

    logic signed [6:0] ih, iw;
    logic tap_ok, last_tap;
    assign ih = 7'(signed'({2'b0, job_reg.row})) + 7'(signed'({4'b0, fh_reg}))
              - 7'(signed'({4'b0, cfg.kh[2:1]}));
    assign iw = 7'(signed'({2'b0, job_reg.col})) + 7'(signed'({4'b0, fw_reg}))
              - 7'(signed'({4'b0, cfg.kw[2:1]}));
    assign tap_ok = !ih[6] && !iw[6] && (ih[5:0] < cfg.h) && (iw[5:0] < cfg.w);
    assign last_tap = ({1'b0, ic_reg} == cfg.nin - 5'd1) && (fh_reg == cfg.kh - 3'd1)
                    && (fw_reg == cfg.kw - 3'd1);

    assign act_raddr  = act_addr(ih[4:0], iw[4:0], ic_reg);
    assign wgt_raddr  = wgt_addr(job_reg.oc, ic_reg, fh_reg, fw_reg);
    // bias read is issued at the pop, so it addresses the queue head
    assign bias_raddr = BiasAw'((st_reg == ST_IDLE) ? job.oc : job_reg.oc);
    assign job_ready  = (st_reg == ST_IDLE);
    assign m_tvalid   = (st_reg == ST_OUT);
    assign m_tdata    = out_reg;
    assign m_tuser    = sat_reg;

    logic signed [AccW-1:0] rnd;
    assign rnd = acc_reg + AccW'(2048);

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:  if (job_valid) st_next = ST_BIAS;
            ST_BIAS:  st_next = ST_RUN;
            ST_RUN:   if (last_tap) st_next = ST_DRAIN;
            ST_DRAIN: if (!rd_v_reg && !mul_v_reg) st_next = ST_OUT;
            ST_OUT:   if (m_tready) st_next = ST_IDLE;
            default:  st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE; rd_v_reg <= 1'b0; mul_v_reg <= 1'b0;
        end else begin
            st_reg    <= st_next;
            rd_v_reg  <= (st_reg == ST_RUN) && tap_ok;
            mul_v_reg <= rd_v_reg;
        end
        if (st_reg == ST_IDLE) begin
            job_reg <= job;
            ic_reg <= '0; fh_reg <= '0; fw_reg <= '0;
        end
        if (st_reg == ST_BIAS)
            acc_reg <= AccW'(signed'(bias_rdata)) <<< 8;
        else if (mul_v_reg)
            acc_reg <= acc_reg + AccW'(prod_reg);
        if (st_reg == ST_RUN) begin
            if (fw_reg == cfg.kw - 3'd1) begin
                fw_reg <= '0;
                if (fh_reg == cfg.kh - 3'd1) begin
                    fh_reg <= '0;
                    ic_reg <= ic_reg + 4'd1;
                end else fh_reg <= fh_reg + 3'd1;
            end else fw_reg <= fw_reg + 3'd1;
        end
        prod_reg <= signed'(act_rdata) * signed'(wgt_rdata);
        if (st_reg == ST_DRAIN) begin
            out_reg[13:0] <= {job_reg.oc, job_reg.col, job_reg.row};
            out_reg[31:29] <= '0;
            if (acc_reg <= 0) begin
                out_reg[28:14] <= '0; sat_reg <= 1'b0;
            end else if (rnd[AccW-1:12] > (AccW-12)'(32767)) begin
                out_reg[28:14] <= 15'h7FFF; sat_reg <= 1'b1;
            end else begin
                out_reg[28:14] <= rnd[26:12]; sat_reg <= 1'b0;
            end
        end
    end
endmodule

>>> sv/conv2d_same_pad_relu.sv
// Top level: same-padded 2-D convolution with ReLU, built from front, back and RAMs.
//  channel | dir | handshake         | payload
//  cfg     | in  | cfg_valid/ready   | cfg_index[2:0], cfg_data[5:0]
//  s_      | in  | s_tvalid/tready   | s_tdata[47:0]
//  m_      | out | m_tvalid/tready   | m_tdata[31:0], m_tuser
// Loads are written to the stores when accepted. A compute runs on one MAC: it walks
// the kh*kw*nin taps with one RAM read per tap, then drains the pipe.
// Reset is synchronous, active low; stores hold junk until written.
// A two-entry job queue takes computes while the MAC is busy; loads wait until
// the queue is empty and the MAC idle, including while a result waits on m_tready.
module conv2d_same_pad_relu (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [5:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operation, row, col, in_chan, out_chan, tap_row, tap_col, load_value
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // res_row, res_col, res_chan, res_value
    output logic [31:0] m_tdata,
    // saturated
    output logic        m_tuser
);
    import c2d_pkg::*;

    cfg_t cfg;
    job_t job;
    logic job_valid, job_ready, act_we, wgt_we, bias_we;
    logic [ActAw-1:0] act_waddr, act_raddr;
    logic [WgtAw-1:0] wgt_waddr, wgt_raddr;
    logic [BiasAw-1:0] bias_waddr, bias_raddr;
    logic [15:0] wdata, act_rdata, wgt_rdata, bias_rdata;

    c2d_front u_front (.aclk, .aresetn, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .s_tvalid, .s_tready, .s_tdata, .cfg, .act_we, .act_waddr, .wgt_we, .wgt_waddr,
        .bias_we, .bias_waddr, .wdata, .job_valid, .job_ready, .job);

    c2d_ram #(.Width(16), .Depth(ActDepth)) u_act (.aclk, .we(act_we), .waddr(act_waddr),
        .wdata, .raddr(act_raddr), .rdata(act_rdata));
    c2d_ram #(.Width(16), .Depth(WgtDepth)) u_wgt (.aclk, .we(wgt_we), .waddr(wgt_waddr),
        .wdata, .raddr(wgt_raddr), .rdata(wgt_rdata));
    c2d_ram #(.Width(16), .Depth(BiasDepth)) u_bias (.aclk, .we(bias_we), .waddr(bias_waddr),
        .wdata, .raddr(bias_raddr), .rdata(bias_rdata));

    c2d_back u_back (.aclk, .aresetn, .cfg, .job_valid, .job_ready, .job, .act_raddr,
        .act_rdata, .wgt_raddr, .wgt_rdata, .bias_raddr, .bias_rdata, .m_tvalid, .m_tready,
        .m_tdata, .m_tuser);
endmodule

>>> sv/c2d_checker.sv
// Port-level checker for the conv2d block, bound to the top level.
module c2d_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_sat_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[28:14] == 15'h7FFF)
        else $error("saturated flag without max value");
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[31:29] == 3'd0)
        else $error("padding bits set");
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
endmodule

bind conv2d_same_pad_relu c2d_checker u_chk (.aclk, .aresetn,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser);

>>> verif/conv2d_same_pad_relu_checker.sv
// Checker: watches the conv2d channels, predicts each compute result and compares.
`timescale 1ns / 100ps

module conv2d_same_pad_relu_checker
    import c2d_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [5:0]  cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tuser,
    output int          errors,
    output int          pending
);

    typedef struct {
        logic [4:0]  row;
        logic [4:0]  col;
        logic [3:0]  chan;
        logic [14:0] value;
        logic        sat;
    } conv_out_t;

    logic [15:0] act_mem [ActDepth];
    logic [15:0] wgt_mem [WgtDepth];
    logic [15:0] bias_mem [MaxOutChannels];
    logic [5:0]  map_h, map_w;
    logic [2:0]  ker_h, ker_w;
    logic [4:0]  n_in, n_out;
    conv_out_t   conv_q [$];

    initial begin
        errors  = 0;
        pending = 0;
        foreach (act_mem[i]) act_mem[i] = '0;
        foreach (wgt_mem[i]) wgt_mem[i] = '0;
        foreach (bias_mem[i]) bias_mem[i] = '0;
    end

    function automatic int clip(input int v, input int hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Returns 1 and fills res when the position and output channel are inside the configured map.
    function automatic bit conv_point(input logic [4:0] r, input logic [4:0] c,
                                      input logic [3:0] oc, output conv_out_t res);
        int     h, w, kh, kw, nin, nout, ih, iw;
        longint acc, rounded;
        h    = clip(map_h, MaxHeight);
        w    = clip(map_w, MaxWidth);
        kh   = clip(ker_h, MaxKernel);
        kw   = clip(ker_w, MaxKernel);
        nin  = clip(n_in, MaxInChannels);
        nout = clip(n_out, MaxOutChannels);
        if (r >= h || c >= w || oc >= nout) return 0;
        acc = longint'($signed(bias_mem[oc])) * 256;
        for (int i = 0; i < nin; i++)
            for (int fh = 0; fh < kh; fh++)
                for (int fw = 0; fw < kw; fw++) begin
                    ih = int'(r) + fh - kh / 2;
                    iw = int'(c) + fw - kw / 2;
                    if (ih >= 0 && ih < h && iw >= 0 && iw < w)
                        acc += longint'($signed(act_mem[(ih * MaxWidth + iw) * MaxInChannels + i]))
                             * longint'($signed(wgt_mem[((oc * MaxInChannels + i) * MaxKernel + fh)
                                                        * MaxKernel + fw]));
                end
        res.row   = r;
        res.col   = c;
        res.chan  = oc;
        res.sat   = 1'b0;
        res.value = '0;
        if (acc > 0) begin
            rounded = (acc + 2048) >>> 12;
            if (rounded > 32767) begin
                res.value = 15'h7fff;
                res.sat   = 1'b1;
            end else begin
                res.value = rounded[14:0];
            end
        end
        return 1;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t conv2d mismatch: %s got %0d want %0d", $time, what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        logic [1:0]  op;
        logic [4:0]  row, col;
        logic [3:0]  ic, oc;
        logic [2:0]  tr, tc;
        logic [15:0] val;
        conv_out_t   res, want;
        if (!aresetn) begin
            map_h <= 6'd32;
            map_w <= 6'd32;
            ker_h <= 3'd3;
            ker_w <= 3'd3;
            n_in  <= 5'd16;
            n_out <= 5'd16;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MAP_H:  map_h <= cfg_data;
                    REG_MAP_W:  map_w <= cfg_data;
                    REG_KER_H:  ker_h <= cfg_data[2:0];
                    REG_KER_W:  ker_w <= cfg_data[2:0];
                    REG_IN_CH:  n_in  <= cfg_data[4:0];
                    REG_OUT_CH: n_out <= cfg_data[4:0];
                    default: ;
                endcase
            end
            // results first, so a result is never matched to a compute accepted in the same cycle
            if (m_tvalid && m_tready) begin
                if (conv_q.size() == 0) begin
                    report("unexpected result, row", m_tdata[4:0], 0);
                end else begin
                    want = conv_q.pop_front();
                    if (m_tdata[4:0] != want.row)     report("res_row", m_tdata[4:0], want.row);
                    if (m_tdata[9:5] != want.col)     report("res_col", m_tdata[9:5], want.col);
                    if (m_tdata[13:10] != want.chan)  report("res_chan", m_tdata[13:10], want.chan);
                    if (m_tdata[28:14] != want.value) report("res_value", m_tdata[28:14], want.value);
                    if (m_tuser != want.sat)          report("saturated", m_tuser, want.sat);
                end
            end
            if (s_tvalid && s_tready) begin
                op  = s_tdata[1:0];
                row = s_tdata[6:2];
                col = s_tdata[11:7];
                ic  = s_tdata[15:12];
                oc  = s_tdata[19:16];
                tr  = s_tdata[22:20];
                tc  = s_tdata[25:23];
                val = s_tdata[41:26];
                case (op_t'(op))
                    OP_LOAD_ACT:  act_mem[(row * MaxWidth + col) * MaxInChannels + ic] = val;
                    OP_LOAD_WGT:
                        if (tr < MaxKernel && tc < MaxKernel)
                            wgt_mem[((oc * MaxInChannels + ic) * MaxKernel + tr) * MaxKernel + tc] = val;
                    OP_LOAD_BIAS: bias_mem[oc] = val;
                    OP_COMPUTE:   if (conv_point(row, col, oc, res)) conv_q.push_back(res);
                    default: ;
                endcase
            end
            pending <= conv_q.size();
        end
    end

endmodule

>>> verif/tb_conv2d_same_pad_relu.sv
// Testbench top: drives loads, computes and register writes into conv2d and gives the verdict.
`timescale 1ns / 100ps

module tb_conv2d_same_pad_relu;
    import c2d_pkg::*;

    localparam int StallLimit = 5000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [5:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    int          errors, pending;
    int          quiet_cycles = 0;
    bit          burst = 1'b0;

    // what has been written, so no compute reads an unwritten entry
    bit act_done [ActDepth];
    bit wgt_done [WgtDepth];
    bit bias_done [MaxOutChannels];
    int h = 32, w = 32, kh = 3, kw = 3, nin = 16, nout = 16;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    conv2d_same_pad_relu uut (.*);

    conv2d_same_pad_relu_checker chk (.*);

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
            $display("tb_conv2d_same_pad_relu failed");
            $finish;
        end
    end

    // result side back-pressure
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            stall = burst ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    function automatic int clip(input int v, input int hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic put_item(input op_t op, input int r, input int c, input int ic,
                            input int oc, input int tr, input int tc, input logic [15:0] val);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, val, 3'(tc), 3'(tr), 4'(oc), 4'(ic), 5'(c), 5'(r), op};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        case (op)
            OP_LOAD_ACT:  act_done[(r * MaxWidth + c) * MaxInChannels + ic] = 1'b1;
            OP_LOAD_WGT:
                if (tr < MaxKernel && tc < MaxKernel)
                    wgt_done[((oc * MaxInChannels + ic) * MaxKernel + tr) * MaxKernel + tc] = 1'b1;
            OP_LOAD_BIAS: bias_done[oc] = 1'b1;
            default: ;
        endcase
    endtask

    // Loads whatever this output position would read that is still unwritten, then computes.
    task automatic compute_at(input int r, input int c, input int oc);
        int ih, iw;
        if (r < h && c < w && oc < nout) begin
            if (!bias_done[oc]) put_item(OP_LOAD_BIAS, 0, 0, 0, oc, 0, 0, 16'($urandom));
            for (int i = 0; i < nin; i++)
                for (int fh = 0; fh < kh; fh++)
                    for (int fw = 0; fw < kw; fw++) begin
                        ih = r + fh - kh / 2;
                        iw = c + fw - kw / 2;
                        if (ih >= 0 && ih < h && iw >= 0 && iw < w) begin
                            if (!act_done[(ih * MaxWidth + iw) * MaxInChannels + i])
                                put_item(OP_LOAD_ACT, ih, iw, i, 0, 0, 0, 16'($urandom));
                            if (!wgt_done[((oc * MaxInChannels + i) * MaxKernel + fh) * MaxKernel + fw])
                                put_item(OP_LOAD_WGT, 0, 0, i, oc, fh, fw, 16'($urandom));
                        end
                    end
        end
        put_item(OP_COMPUTE, r, c, 0, oc, 0, 0, 16'($urandom));
    endtask

    task automatic write_reg(input reg_idx_t idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 6'(val);
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_MAP_H:  h    = clip(val & 63, MaxHeight);
            REG_MAP_W:  w    = clip(val & 63, MaxWidth);
            REG_KER_H:  kh   = clip(val & 7, MaxKernel);
            REG_KER_W:  kw   = clip(val & 7, MaxKernel);
            REG_IN_CH:  nin  = clip(val & 31, MaxInChannels);
            REG_OUT_CH: nout = clip(val & 31, MaxOutChannels);
            default: ;
        endcase
    endtask

    // waits out outstanding results and any compute that produces none
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (450) @(negedge aclk);
    endtask

    task automatic set_map(input int vh, input int vw, input int vkh, input int vkw,
                           input int vin, input int vout);
        settle();
        write_reg(REG_MAP_H, vh);
        write_reg(REG_MAP_W, vw);
        write_reg(REG_KER_H, vkh);
        write_reg(REG_KER_W, vkw);
        write_reg(REG_IN_CH, vin);
        write_reg(REG_OUT_CH, vout);
    endtask

    task automatic random_items(input int count, input int max_computes);
        int sel, computes;
        computes = 0;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) burst = ($urandom_range(0, 3) == 0);
            sel = $urandom_range(0, 99);
            if (sel < 45 && computes < max_computes) begin
                computes++;
                if ($urandom_range(0, 7) == 0)
                    compute_at($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 15));
                else
                    compute_at($urandom_range(0, h - 1), $urandom_range(0, w - 1),
                               $urandom_range(0, nout - 1));
            end else if (sel < 65) begin
                put_item(OP_LOAD_ACT, $urandom_range(0, h - 1), $urandom_range(0, w - 1),
                         $urandom_range(0, nin - 1), $urandom_range(0, 15), $urandom_range(0, 7),
                         $urandom_range(0, 7), 16'($urandom));
            end else if (sel < 85) begin
                put_item(OP_LOAD_WGT, $urandom_range(0, 31), $urandom_range(0, 31),
                         $urandom_range(0, nin - 1), $urandom_range(0, nout - 1),
                         $urandom_range(0, kh - 1), $urandom_range(0, kw - 1), 16'($urandom));
            end else if (sel < 92) begin
                put_item(OP_LOAD_BIAS, $urandom_range(0, 31), $urandom_range(0, 31),
                         $urandom_range(0, 15), $urandom_range(0, nout - 1), 0, 0, 16'($urandom));
            end else begin
                // loads anywhere, including taps past the filter bound that get dropped
                put_item($urandom_range(0, 1) ? OP_LOAD_WGT : OP_LOAD_ACT,
                         $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 15),
                         $urandom_range(0, 15), $urandom_range(0, 7), $urandom_range(0, 7),
                         16'($urandom));
            end
        end
        burst = 1'b0;
    endtask

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // 1x1 map, single tap: saturation, ReLU clipping and rounding
        set_map(1, 1, 1, 1, 1, 1);
        put_item(OP_LOAD_ACT, 0, 0, 0, 0, 0, 0, 16'h7fff);
        put_item(OP_LOAD_WGT, 0, 0, 0, 0, 0, 0, 16'h7fff);
        put_item(OP_LOAD_BIAS, 0, 0, 0, 0, 0, 0, 16'h7fff);
        compute_at(0, 0, 0);
        put_item(OP_LOAD_ACT, 0, 0, 0, 0, 0, 0, 16'h8000);
        compute_at(0, 0, 0);
        put_item(OP_LOAD_ACT, 0, 0, 0, 0, 0, 0, 16'h0000);
        put_item(OP_LOAD_BIAS, 0, 0, 0, 0, 0, 0, 16'h8000);
        compute_at(0, 0, 0);
        put_item(OP_LOAD_BIAS, 0, 0, 0, 0, 0, 0, 16'd8);   // rounds up to one LSB
        compute_at(0, 0, 0);
        put_item(OP_LOAD_BIAS, 0, 0, 0, 0, 0, 0, 16'd7);   // rounds down to zero
        compute_at(0, 0, 0);
        compute_at(1, 0, 0);                               // outside the map: no result
        compute_at(0, 31, 0);
        compute_at(0, 0, 15);                              // channel past output_channels
        put_item(OP_LOAD_WGT, 0, 0, 0, 0, 7, 0, 16'h1234); // taps past the bound are dropped
        put_item(OP_LOAD_WGT, 0, 0, 0, 0, 0, 5, 16'h1234);
        put_item(OP_LOAD_ACT, 31, 31, 15, 15, 7, 7, 16'hffff);
        compute_at(0, 0, 0);
        random_items(40, 1000);

        set_map(4, 5, 3, 3, 2, 3);
        random_items(50, 1000);

        // zero registers clamp to one, oversized kernel to the bound; spare indexes ignored
        settle();
        write_reg(reg_idx_t'(3'd6), 6'h3f);
        write_reg(reg_idx_t'(3'd7), 6'h15);
        set_map(0, 2, 7, 4, 0, 2);
        random_items(60, 1000);

        // map, kernel and output channels past their bounds
        set_map(63, 63, 7, 7, 1, 31);
        random_items(20, 2);

        // input channels past the bound
        set_map(2, 2, 1, 1, 31, 31);
        random_items(20, 2);

        set_map(7, 3, 2, 5, 3, 4);
        random_items(50, 1000);

        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (450) @(negedge aclk);
        if (errors == 0 && pending == 0)
            $display("tb_conv2d_same_pad_relu passed");
        else
            $display("tb_conv2d_same_pad_relu failed");
        $finish;
    end

endmodule
